// ----- rtl/abf_pkg.sv -----
// Shared types and codes for the data-processing ALU with barrel shifter.
`default_nettype none
package abf_pkg;

   // Opcodes
   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   // Shift types
   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   // Flag bit positions
   localparam int FL_N = 3;
   localparam int FL_Z = 2;
   localparam int FL_C = 1;
   localparam int FL_V = 0;

   localparam logic [7:0] FULL_SHIFT = 8'd32;

   typedef struct packed {
      logic [3:0]  mode;
      logic        imm_form;
      logic        update_flags;
      logic [1:0]  shift_kind;
      logic        amt_from_reg;
      logic [4:0]  shift_imm;
      logic [3:0]  rotate_imm;
      logic [7:0]  imm8;
      logic [31:0] first_operand;
      logic [31:0] second_operand;
      logic [7:0]  shift_reg_byte;
      logic [3:0]  flags_in;
   } req_item_type;

   typedef struct packed {
      logic [31:0] result;
      logic        write_result;
      logic [3:0]  flags_out;
   } rsp_item_type;

   // Second operand with its shifter carry
   typedef struct packed {
      logic [31:0] value;
      logic        carry;
   } operand_type;

endpackage
`default_nettype wire

// ----- rtl/abf_shifter.sv -----
// Second-operand path: rotated immediate or barrel shift of a register.
`default_nettype none
module abf_shifter (
   input  wire abf_pkg::req_item_type item,
   output abf_pkg::operand_type       operand
);

   logic [31:0] v;
   logic        cin;
   logic [7:0]  amt;
   logic [4:0]  amt5;
   logic        imm_amt;
   logic [32:0] lsl_ext;
   logic [32:0] lsr_ext;
   logic [32:0] asr_ext;
   logic [63:0] ror_ext;
   logic [63:0] imm_ext;
   logic [31:0] ror_val;
   logic [31:0] imm_val;

   assign v       = item.second_operand;
   assign cin     = item.flags_in[abf_pkg::FL_C];
   assign imm_amt = !item.amt_from_reg;

   // Pick the shift amount; immediate LSR or ASR by zero means by 32
   always_comb begin
      amt = item.amt_from_reg ? item.shift_reg_byte : {3'b000, item.shift_imm};
      if (imm_amt && (item.shift_imm == 5'd0)
          && ((item.shift_kind == abf_pkg::SH_LSR)
              || (item.shift_kind == abf_pkg::SH_ASR))) begin
         amt = abf_pkg::FULL_SHIFT;
      end
   end

   assign amt5 = amt[4:0];

   // Shift candidates with one extra bit catching the carry
   assign lsl_ext = {1'b0, v} << amt5;
   assign lsr_ext = {v, 1'b0} >> amt5;
   assign asr_ext = 33'($signed({v, 1'b0}) >>> amt5);
   assign ror_ext = {v, v} >> amt5;
   assign ror_val = ror_ext[31:0];
   assign imm_ext = {24'd0, item.imm8, 24'd0, item.imm8} >> {item.rotate_imm, 1'b0};
   assign imm_val = imm_ext[31:0];

   // Select value and carry
   always_comb begin
      operand.value = v;
      operand.carry = cin;
      if (item.imm_form) begin
         operand.value = imm_val;
         if (item.rotate_imm != 4'd0) begin
            operand.carry = imm_val[31];
         end
      end else begin
         case (item.shift_kind)
            abf_pkg::SH_LSL: begin
               if (amt == 8'd0) begin
               end else if (amt < abf_pkg::FULL_SHIFT) begin
                  operand.value = lsl_ext[31:0];
                  operand.carry = lsl_ext[32];
               end else if (amt == abf_pkg::FULL_SHIFT) begin
                  operand.value = 32'd0;
                  operand.carry = v[0];
               end else begin
                  operand.value = 32'd0;
                  operand.carry = 1'b0;
               end
            end
            abf_pkg::SH_LSR: begin
               if (amt == 8'd0) begin
               end else if (amt < abf_pkg::FULL_SHIFT) begin
                  operand.value = lsr_ext[32:1];
                  operand.carry = lsr_ext[0];
               end else if (amt == abf_pkg::FULL_SHIFT) begin
                  operand.value = 32'd0;
                  operand.carry = v[31];
               end else begin
                  operand.value = 32'd0;
                  operand.carry = 1'b0;
               end
            end
            abf_pkg::SH_ASR: begin
               if (amt == 8'd0) begin
               end else if (amt < abf_pkg::FULL_SHIFT) begin
                  operand.value = asr_ext[32:1];
                  operand.carry = asr_ext[0];
               end else begin
                  operand.value = {32{v[31]}};
                  operand.carry = v[31];
               end
            end
            default: begin
               // Immediate ROR by zero is RRX
               if (imm_amt && (amt == 8'd0)) begin
                  operand.value = {cin, v[31:1]};
                  operand.carry = v[0];
               end else if (amt != 8'd0) begin
                  operand.value = ror_val;
                  operand.carry = ror_val[31];
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/abf_alu.sv -----
// ALU core: logic ops, adder and NZCV flag update.
`default_nettype none
module abf_alu (
   input  wire abf_pkg::req_item_type item,
   input  wire abf_pkg::operand_type  operand,
   output abf_pkg::rsp_item_type      rsp
);

   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] add_x;
   logic [31:0] add_y;
   logic        add_c;
   logic [32:0] sum;
   logic [31:0] add_r;
   logic [31:0] logic_r;
   logic        is_logic;
   logic        is_test;
   logic        upd;
   logic [31:0] res;
   logic        cin;

   assign a   = item.first_operand;
   assign b   = operand.value;
   assign cin = item.flags_in[abf_pkg::FL_C];

   // Decode opcode into adder operands and logic result
   always_comb begin
      add_x    = a;
      add_y    = b;
      add_c    = 1'b0;
      logic_r  = 32'd0;
      is_logic = 1'b0;
      is_test  = 1'b0;
      case (item.mode)
         abf_pkg::OP_AND: begin logic_r = a & b; is_logic = 1'b1; end
         abf_pkg::OP_EOR: begin logic_r = a ^ b; is_logic = 1'b1; end
         abf_pkg::OP_SUB: begin add_y = ~b; add_c = 1'b1; end
         abf_pkg::OP_RSB: begin add_x = b; add_y = ~a; add_c = 1'b1; end
         abf_pkg::OP_ADD: begin end
         abf_pkg::OP_ADC: begin add_c = cin; end
         abf_pkg::OP_SBC: begin add_y = ~b; add_c = cin; end
         abf_pkg::OP_RSC: begin add_x = b; add_y = ~a; add_c = cin; end
         abf_pkg::OP_TST: begin logic_r = a & b; is_logic = 1'b1; is_test = 1'b1; end
         abf_pkg::OP_TEQ: begin logic_r = a ^ b; is_logic = 1'b1; is_test = 1'b1; end
         abf_pkg::OP_CMP: begin add_y = ~b; add_c = 1'b1; is_test = 1'b1; end
         abf_pkg::OP_CMN: begin is_test = 1'b1; end
         abf_pkg::OP_ORR: begin logic_r = a | b; is_logic = 1'b1; end
         abf_pkg::OP_MOV: begin logic_r = b; is_logic = 1'b1; end
         abf_pkg::OP_BIC: begin logic_r = a & ~b; is_logic = 1'b1; end
         abf_pkg::OP_MVN: begin logic_r = ~b; is_logic = 1'b1; end
         default: begin end
      endcase
   end

   // Add with carry out in the top bit
   assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};
   assign add_r = sum[31:0];
   assign res   = is_logic ? logic_r : add_r;
   assign upd   = item.update_flags || is_test;

   // Build the result item
   always_comb begin
      rsp.result       = is_test ? 32'd0 : res;
      rsp.write_result = !is_test;
      rsp.flags_out    = item.flags_in;
      if (upd) begin
         rsp.flags_out[abf_pkg::FL_N] = res[31];
         rsp.flags_out[abf_pkg::FL_Z] = (res == 32'd0);
         if (is_logic) begin
            rsp.flags_out[abf_pkg::FL_C] = operand.carry;
         end else begin
            rsp.flags_out[abf_pkg::FL_C] = sum[32];
            rsp.flags_out[abf_pkg::FL_V] = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_r[31]);
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/alu_barrel_shifter_flags_unit.sv -----
// Top level: input register, shifter and ALU, result register.
//
//   channel   ports                        handshake
//   request   start, busy, req_item        taken when start is high and busy low
//   response  rsp_strobe, rsp_item         valid for the one cycle rsp_strobe is high
//
// One item per cycle; busy stays low. The edge that takes an item loads the input
// register; the shifter and ALU work on it and the result register captures their
// output, which is presented on rsp_item with rsp_strobe.
// Synchronous reset drops any item in flight.
// The receiver cannot hold results off, so nothing stalls.
`default_nettype none
module alu_barrel_shifter_flags_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire abf_pkg::req_item_type req_item,
   output logic                       rsp_strobe,
   output abf_pkg::rsp_item_type      rsp_item
);

   abf_pkg::req_item_type item_ff;
   logic                  item_valid_ff;
   logic                  item_valid_in;
   abf_pkg::operand_type  operand;
   abf_pkg::rsp_item_type rsp_in;
   abf_pkg::rsp_item_type rsp_ff;
   logic                  strobe_ff;

   assign busy          = 1'b0;
   assign item_valid_in = start && !busy;

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (item_valid_in) begin
         item_ff <= req_item;
      end
   end

   abf_shifter u_shifter (
      .item    (item_ff),
      .operand (operand)
   );

   abf_alu u_alu (
      .item    (item_ff),
      .operand (operand),
      .rsp     (rsp_in)
   );

   // Register the result and its strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= item_valid_ff;
      end
      if (item_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire
